// ===== hw/rtl/substring_position_search_top_macros.svh =====
`ifndef SUBSTRING_POSITION_SEARCH_TOP_MACROS_SVH
`define SUBSTRING_POSITION_SEARCH_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, quiet while rst is high.
`define SPS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, quiet while rst is high.
`define SPS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/sps_pkg.sv =====
`default_nettype none

package sps_pkg;

  localparam int PATTERN_MAX    = 16;
  localparam int POSITION_WIDTH = 16;

  localparam int FIELD_W   = 16;
  localparam int CFG_W     = 64;
  localparam int PLEN_W    = 5;
  localparam int REG_IDX_W = 2;
  localparam int LEN_W     = $clog2(PATTERN_MAX + 1);
  localparam int IDX_W     = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int WIN_DEPTH = (PATTERN_MAX > 1) ? PATTERN_MAX - 1 : 1;

  localparam logic [7:0] CHAR_END = 8'h00;
  localparam logic [POSITION_WIDTH-1:0] POS_LIMIT = {POSITION_WIDTH{1'b1}};

  typedef enum logic [REG_IDX_W-1:0] {
    REG_PATTERN_LOW  = 2'd0,
    REG_PATTERN_HIGH = 2'd1,
    REG_PATTERN_LEN  = 2'd2,
    REG_SEARCH_LAST  = 2'd3
  } sps_reg_t;

  // Pattern as seen from the newest byte: rev[d] pairs with the byte d places back.
  typedef struct packed {
    logic [PATTERN_MAX-1:0][7:0] rev;
    logic [PATTERN_MAX-1:0]      mask;
    logic [LEN_W-1:0]            used_len;
    logic                        search_last;
  } sps_cfg_t;

  function automatic logic [FIELD_W-1:0] pos_field(input logic [POSITION_WIDTH-1:0] v);
    logic [POSITION_WIDTH+FIELD_W-1:0] w;
    w = {{FIELD_W{1'b0}}, v};
    return w[FIELD_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/substring_position_search_top.sv =====
`default_nettype none

// Substring position search: bytes of a string stream in one per transfer and
// are compared, one byte per cycle, against a configured pattern of up to 16
// bytes through a 16-byte window compare. A zero byte ends the string and
// yields one result transfer (position, found flag, length, too_long); other
// bytes yield nothing. An accepted byte is held in the input register until it
// is consumed; a terminator's result is registered into the outputs when the
// terminator is consumed. Throughput is one byte per cycle; only a terminator
// waits, and only while the previous result is still held by out_stall. Write
// configuration only while no string is in flight.

`include "substring_position_search_top_macros.svh"

module substring_position_search_top
  import sps_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_wr_en,
  input  wire logic [REG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [7:0]           char_code,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [FIELD_W-1:0]        match_position,
  output logic                      match_found,
  output logic [FIELD_W-1:0]        string_length,
  output logic                      too_long
);

  sps_cfg_t cfg;

  sps_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Input register
  logic       in_full;
  logic [7:0] char_r;
  logic       in_term;
  logic       take;
  logic       fire;

  assign in_term  = char_r == CHAR_END;
  assign take     = !in_term || !out_valid || !out_stall;
  assign fire     = in_full && take;
  assign in_stall = in_full && !take;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (!in_stall) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      char_r <= char_code;
    end
  end

  // Per-string state
  logic [POSITION_WIDTH-1:0] byte_index;
  logic                      seen_match;
  logic [POSITION_WIDTH-1:0] kept_position;
  logic                      length_overflow;

  logic                      win_hit;
  logic                      advance;
  logic                      len_nz;
  logic                      enough;
  logic                      match_now;
  logic [POSITION_WIDTH-1:0] start_pos;

  assign advance = fire && !in_term;

  sps_window u_window (
    .clk     (clk),
    .advance (advance),
    .char_in (char_r),
    .cfg     (cfg),
    .hit     (win_hit)
  );

  assign len_nz    = cfg.used_len != '0;
  assign enough    = ({1'b0, byte_index} + (POSITION_WIDTH + 1)'(1))
                     >= (POSITION_WIDTH + 1)'(cfg.used_len);
  assign match_now = len_nz && enough && win_hit;
  assign start_pos = byte_index + POSITION_WIDTH'(1) - POSITION_WIDTH'(cfg.used_len);

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index      <= '0;
      seen_match      <= 1'b0;
      kept_position   <= '0;
      length_overflow <= 1'b0;
    end else if (fire && in_term) begin
      byte_index      <= '0;
      seen_match      <= 1'b0;
      kept_position   <= '0;
      length_overflow <= 1'b0;
    end else if (advance) begin
      if (match_now) begin
        if (cfg.search_last || !seen_match) begin
          kept_position <= start_pos;
        end
        seen_match <= 1'b1;
      end
      // Hold the index at its limit and flag the overflow.
      if (byte_index == POS_LIMIT) begin
        length_overflow <= 1'b1;
      end else begin
        byte_index <= byte_index + POSITION_WIDTH'(1);
      end
    end
  end

  // Result
  logic                      slen_nz;
  logic                      found_next;
  logic [POSITION_WIDTH-1:0] pos_next;

  assign slen_nz = byte_index != '0;

  always_comb begin
    if (!len_nz) begin
      found_next = slen_nz;
      pos_next   = (cfg.search_last && slen_nz) ? byte_index - POSITION_WIDTH'(1) : '0;
    end else begin
      found_next = seen_match;
      if (seen_match) begin
        pos_next = kept_position;
      end else begin
        pos_next = cfg.search_last ? '0 : byte_index;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire && in_term) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && in_term) begin
      match_position <= pos_field(pos_next);
      match_found    <= found_next;
      string_length  <= pos_field(byte_index);
      too_long       <= length_overflow;
    end
  end

  `SPS_ASSERT_NOW(a_overflow_at_limit, length_overflow, byte_index == POS_LIMIT, "overflow flag set below the index limit")
  `SPS_ASSERT_NOW(a_kept_needs_match, !seen_match, kept_position == '0, "position kept without a match")
  `SPS_ASSERT_NOW(a_bytes_never_wait, in_full && !in_term, !in_stall, "non-terminator byte held back")
  `SPS_ASSERT_NEXT(a_result_loaded, fire && in_term, out_valid && string_length == pos_field($past(byte_index)), "terminator did not load its result")

endmodule

`default_nettype wire

// ===== hw/rtl/sps_cfg.sv =====
`default_nettype none

module sps_cfg
  import sps_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_wr_en,
  input  wire logic [REG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  output sps_cfg_t                  cfg
);

  logic [CFG_W-1:0]  pattern_low;
  logic [CFG_W-1:0]  pattern_high;
  logic [PLEN_W-1:0] pattern_length;
  logic              search_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_low    <= '0;
      pattern_high   <= '0;
      pattern_length <= '0;
      search_last    <= 1'b0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_PATTERN_LOW:  pattern_low    <= cfg_data;
        REG_PATTERN_HIGH: pattern_high   <= cfg_data;
        REG_PATTERN_LEN:  pattern_length <= cfg_data[PLEN_W-1:0];
        REG_SEARCH_LAST:  search_last    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Bytes past the two data registers read as zero.
  logic [8*PATTERN_MAX+2*CFG_W-1:0] all_bytes;
  logic [PATTERN_MAX-1:0][7:0]      pbyte;
  logic [LEN_W-1:0]                 used_len;
  logic [LEN_W-1:0]                 diff;

  assign all_bytes = {{(8*PATTERN_MAX){1'b0}}, pattern_high, pattern_low};

  always_comb begin
    for (int j = 0; j < PATTERN_MAX; j++) begin
      pbyte[j] = all_bytes[8*j +: 8];
    end
  end

  always_comb begin
    if ((LEN_W + PLEN_W)'(pattern_length) > (LEN_W + PLEN_W)'(PATTERN_MAX)) begin
      used_len = LEN_W'(PATTERN_MAX);
    end else begin
      used_len = LEN_W'(pattern_length);
    end
  end

  always_comb begin
    diff = '0;
    for (int d = 0; d < PATTERN_MAX; d++) begin
      diff        = used_len - LEN_W'(d + 1);
      cfg.mask[d] = LEN_W'(d) < used_len;
      cfg.rev[d]  = cfg.mask[d] ? pbyte[diff[IDX_W-1:0]] : 8'h00;
    end
    cfg.used_len    = used_len;
    cfg.search_last = search_last;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/sps_window.sv =====
`default_nettype none

module sps_window
  import sps_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       advance,
  input  wire logic [7:0] char_in,
  input  wire sps_cfg_t   cfg,
  output logic            hit
);

  // Previous bytes, newest first. Only entries inside the current string are
  // ever compared, so no clearing is needed.
  logic [WIN_DEPTH-1:0][7:0] recent;
  logic [PATTERN_MAX-1:0]    eq;

  always_ff @(posedge clk) begin
    if (advance) begin
      recent[0] <= char_in;
      for (int i = 1; i < WIN_DEPTH; i++) begin
        recent[i] <= recent[i-1];
      end
    end
  end

  always_comb begin
    eq[0] = !cfg.mask[0] || (char_in == cfg.rev[0]);
    for (int d = 1; d < PATTERN_MAX; d++) begin
      eq[d] = !cfg.mask[d] || (recent[d-1] == cfg.rev[d]);
    end
  end

  assign hit = &eq;

endmodule

`default_nettype wire

// ===== dv/substring_position_search_top_tb.sv =====
module substring_position_search_top_tb;
  import sps_pkg::*;

  localparam int CYCLE_LIMIT = 700000;
  localparam int RANDOM_BYTES = 1300;

  typedef struct packed {
    logic [FIELD_W-1:0] position;
    logic               found;
    logic [FIELD_W-1:0] string_len;
    logic               too_long;
  } search_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic [REG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] char_code = 8'h00;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [FIELD_W-1:0] match_position;
  logic match_found;
  logic [FIELD_W-1:0] string_length;
  logic too_long;

  substring_position_search_top dut (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .char_code(char_code),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .match_position(match_position),
    .match_found(match_found),
    .string_length(string_length),
    .too_long(too_long)
  );

  always #5 clk = ~clk;

  logic [7:0] pending_bytes[$];
  search_result_t due_results[$];
  int queued_count = 0;
  int accepted_count = 0;
  int mismatch_count = 0;
  int cycle_count = 0;
  bit byte_taken = 1'b0;
  bit quiet_mode = 1'b0;

  // shadow of the configuration registers
  logic [CFG_W-1:0] pat_low_q = '0;
  logic [CFG_W-1:0] pat_high_q = '0;
  logic [PLEN_W-1:0] pat_len_q = '0;
  logic last_mode_q = 1'b0;

  // per-string search state
  logic [7:0] recent_q[WIN_DEPTH];
  logic [POSITION_WIDTH-1:0] byte_idx_q = '0;
  logic seen_q = 1'b0;
  logic [POSITION_WIDTH-1:0] kept_q = '0;
  logic overflow_q = 1'b0;

  function automatic logic [7:0] pattern_at(input int i);
    return (i < 8) ? pat_low_q[8*i +: 8] : pat_high_q[8*(i-8) +: 8];
  endfunction

  task automatic clear_string_state();
    for (int k = 0; k < WIN_DEPTH; k++) recent_q[k] = 8'h00;
    byte_idx_q = '0;
    seen_q = 1'b0;
    kept_q = '0;
    overflow_q = 1'b0;
  endtask

  task automatic advance_search(input logic [7:0] c);
    int span;
    int here;
    int k;
    logic hit;
    search_result_t res;
    span = (pat_len_q > PATTERN_MAX) ? PATTERN_MAX : int'(pat_len_q);
    if (c == CHAR_END) begin
      if (span == 0) begin
        res.found = (byte_idx_q != 0);
        res.position = (last_mode_q && byte_idx_q != 0) ? byte_idx_q - 16'd1 : 16'd0;
      end else begin
        res.found = seen_q;
        res.position = seen_q ? kept_q : (last_mode_q ? 16'd0 : byte_idx_q);
      end
      res.string_len = byte_idx_q;
      res.too_long = overflow_q;
      due_results.push_back(res);
      clear_string_state();
    end else begin
      here = int'(byte_idx_q);
      if (span > 0 && here + 1 >= span) begin
        hit = (c == pattern_at(span - 1));
        for (k = 0; k + 1 < span; k++) begin
          if (recent_q[k] != pattern_at(span - 2 - k)) hit = 1'b0;
        end
        if (hit) begin
          if (last_mode_q || !seen_q) kept_q = POSITION_WIDTH'(here + 1 - span);
          seen_q = 1'b1;
        end
      end
      for (k = WIN_DEPTH - 1; k > 0; k--) recent_q[k] = recent_q[k-1];
      recent_q[0] = c;
      if (byte_idx_q == POS_LIMIT) overflow_q = 1'b1;
      else byte_idx_q = byte_idx_q + 1'b1;
    end
  endtask

  // input side: note each transfer and register write, then predict
  always @(posedge clk) begin
    byte_taken = !rst && in_valid && !in_stall;
    if (!rst && cfg_wr_en) begin
      case (sps_reg_t'(cfg_index))
        REG_PATTERN_LOW: pat_low_q = cfg_data;
        REG_PATTERN_HIGH: pat_high_q = cfg_data;
        REG_PATTERN_LEN: pat_len_q = cfg_data[PLEN_W-1:0];
        REG_SEARCH_LAST: last_mode_q = cfg_data[0];
        default: ;
      endcase
    end
    if (byte_taken) begin
      accepted_count++;
      advance_search(char_code);
    end
  end

  // driver: hold a stalled byte, otherwise present the next one or idle
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || byte_taken) begin
      if (pending_bytes.size() != 0 && (quiet_mode || $urandom_range(99) >= 30)) begin
        in_valid <= 1'b1;
        char_code <= pending_bytes.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    out_stall <= !rst && !quiet_mode && ($urandom_range(99) < 30);
  end

  task automatic flag_mismatch(input string what, input search_result_t want);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("%0t %s: expected pos=%0d found=%0b len=%0d too_long=%0b", $realtime, what,
               want.position, want.found, want.string_len, want.too_long);
      $display("%0t   got pos=%0d found=%0b len=%0d too_long=%0b", $realtime,
               match_position, match_found, string_length, too_long);
    end
  endtask

  // monitor: compare each result transfer against the oldest prediction
  always @(posedge clk) begin
    search_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (due_results.size() == 0) begin
        flag_mismatch("unexpected result", '0);
      end else begin
        want = due_results.pop_front();
        if (match_position !== want.position || match_found !== want.found ||
            string_length !== want.string_len || too_long !== want.too_long) begin
          flag_mismatch("result mismatch", want);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic queue_byte(input logic [7:0] b);
    pending_bytes.push_back(b);
    queued_count++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) queue_byte(s[i]);
    queue_byte(CHAR_END);
  endtask

  function automatic logic [127:0] pack_text(input string s);
    logic [127:0] v;
    v = '0;
    for (int i = 0; i < s.len() && i < 16; i++) v[8*i +: 8] = s[i];
    return v;
  endfunction

  task automatic write_reg(input sps_reg_t idx, input logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic set_search(input logic [127:0] pat, input logic [PLEN_W-1:0] plen,
                            input logic last);
    write_reg(REG_PATTERN_LOW, pat[63:0]);
    write_reg(REG_PATTERN_HIGH, pat[127:64]);
    write_reg(REG_PATTERN_LEN, CFG_W'(plen));
    write_reg(REG_SEARCH_LAST, CFG_W'(last));
  endtask

  // wait until every byte is taken and every result has come back
  task automatic drain();
    do @(negedge clk);
    while (accepted_count != queued_count || due_results.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  initial begin
    logic [47:0] triple_seq;
    logic [127:0] pat;
    logic [7:0] alpha[4];
    logic [7:0] b;
    int plen;
    int used;
    int roll;
    int strings;
    int target;
    int built;
    int cut;
    int rand_start;
    bit narrow;

    clear_string_state();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // empty pattern, first then last mode
    send_text("");
    send_text("x");
    drain();
    write_reg(REG_SEARCH_LAST, 64'd1);
    send_text("");
    send_text("ab");

    // extreme bytes; pattern bytes past the length must be ignored
    drain();
    set_search(128'hDEAD_BEEF_0000_0000_1234_5678_9A80_01FF, 5'd3, 1'b0);
    triple_seq = 48'h80_01_FF_80_01_FF;
    for (int i = 0; i < 6; i++) queue_byte(triple_seq[8*i +: 8]);
    queue_byte(CHAR_END);
    queue_byte(8'hFF);
    queue_byte(8'h01);
    queue_byte(8'h7F);
    queue_byte(CHAR_END);
    drain();
    write_reg(REG_SEARCH_LAST, 64'd1);
    for (int i = 0; i < 6; i++) queue_byte(triple_seq[8*i +: 8]);
    queue_byte(CHAR_END);
    send_text("ab");

    // full-width pattern, then a length above the maximum
    drain();
    set_search(pack_text("ABCDEFGHIJKLMNOP"), 5'd16, 1'b0);
    send_text("zABCDEFGHIJKLMNOP");
    drain();
    set_search(pack_text("ABCDEFGHIJKLMNOP"), 5'd31, 1'b1);
    send_text("zABCDEFGHIJKLMNOP");

    // zero byte inside the pattern never matches
    drain();
    set_search(128'h0061, 5'd2, 1'b0);
    send_text("aaa");

    rand_start = queued_count;
    while (queued_count - rand_start < RANDOM_BYTES) begin
      drain();
      roll = $urandom_range(99);
      if (roll < 5) plen = 0;
      else if (roll < 65) plen = $urandom_range(1, 6);
      else if (roll < 95) plen = $urandom_range(7, 16);
      else plen = $urandom_range(17, 31);
      used = (plen > PATTERN_MAX) ? PATTERN_MAX : plen;
      for (int i = 0; i < 4; i++) alpha[i] = 8'($urandom_range(1, 255));
      narrow = ($urandom_range(99) < 70);
      for (int i = 0; i < 16; i++) begin
        pat[8*i +: 8] = narrow ? alpha[$urandom_range(3)] : 8'($urandom_range(255));
      end
      if (used > 0 && $urandom_range(99) < 4) pat[8*$urandom_range(used - 1) +: 8] = 8'h00;
      quiet_mode = ($urandom_range(99) < 15);
      set_search(pat, PLEN_W'(plen), 1'($urandom_range(1)));
      strings = $urandom_range(3, 8);
      for (int s = 0; s < strings; s++) begin
        target = ($urandom_range(99) < 10) ? $urandom_range(31, 120) : $urandom_range(30);
        built = 0;
        while (built < target) begin
          roll = $urandom_range(99);
          if (roll < 35 && used > 0) begin
            for (int j = 0; j < used; j++) begin
              b = pat[8*j +: 8];
              queue_byte((b == 8'h00) ? 8'h01 : b);
            end
            built += used;
          end else if (roll < 45 && used > 1) begin
            // broken copy: a prefix of the pattern only
            cut = $urandom_range(1, used - 1);
            for (int j = 0; j < cut; j++) begin
              b = pat[8*j +: 8];
              queue_byte((b == 8'h00) ? 8'h01 : b);
            end
            built += cut;
          end else begin
            queue_byte(($urandom_range(99) < 60) ? alpha[$urandom_range(3)]
                                                 : 8'($urandom_range(1, 255)));
            built++;
          end
        end
        queue_byte(CHAR_END);
      end
    end

    drain();
    repeat (10) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/sps_pkg.sv
hw/rtl/sps_cfg.sv
hw/rtl/sps_window.sv
hw/rtl/substring_position_search_top.sv
dv/substring_position_search_top_tb.sv
